/* rtl/tect_pkg.sv */
package tect_pkg;

  // Fixed field widths of the command and configuration words.
  localparam int LOC_BITS  = 16;
  localparam int TIME_W    = 6;
  localparam int MODE_W    = 3;
  localparam int STATUS_W  = 3;
  localparam int NUM_DIRS  = 5;
  localparam int OFF_W     = 17;
  localparam int MC_W      = 17;
  localparam int SUM_W     = OFF_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 17;
  localparam int CNT_W     = $clog2(NUM_DIRS + 1);
  localparam int NSEL_W    = $clog2(NUM_DIRS);

  localparam int DEF_MAX_STEPS      = 64;
  localparam int DEF_PAIRS_PER_STEP = 64;

  typedef logic [LOC_BITS-1:0]  loc_t;
  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [MC_W-1:0]      map_cells_t;
  typedef logic signed [OFF_W-1:0] off_t;
  typedef off_t [NUM_DIRS-1:0]  off_vec_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // Valid neighbors of one vertex, packed to the low entries in direction order.
  typedef struct packed {
    cnt_t                     cnt;
    loc_t [NUM_DIRS-1:0]      list;
  } nbr_t;

  localparam mode_t MODE_PUSH_EDGE = 3'd0;
  localparam mode_t MODE_POP_EDGE  = 3'd1;
  localparam mode_t MODE_PUSH_VTX  = 3'd2;
  localparam mode_t MODE_POP_VTX   = 3'd3;
  localparam mode_t MODE_QUERY     = 3'd4;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_TIME     = 3'd2;
  localparam status_t ST_MISMATCH = 3'd3;
  localparam status_t ST_EMPTY    = 3'd4;

  localparam cfg_idx_t CFG_MAP_CELLS = 3'd0;
  localparam cfg_idx_t CFG_OFFSET0   = 3'd1;
  localparam cfg_idx_t CFG_OFFSET1   = 3'd2;
  localparam cfg_idx_t CFG_OFFSET2   = 3'd3;
  localparam cfg_idx_t CFG_OFFSET3   = 3'd4;
  localparam cfg_idx_t CFG_OFFSET4   = 3'd5;

  localparam map_cells_t MAP_CELLS_RST = 17'd65536;
  localparam off_t OFFSET0_RST = 17'sd0;
  localparam off_t OFFSET1_RST = 17'sd1;
  localparam off_t OFFSET2_RST = -17'sd1;
  localparam off_t OFFSET3_RST = 17'sd256;
  localparam off_t OFFSET4_RST = -17'sd256;

endpackage

/* rtl/tect_ram.sv */
module tect_ram import tect_pkg::*; #(
  parameter int DEPTH = DEF_MAX_STEPS,
  parameter int WIDTH = 2 * LOC_BITS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tect_nbr.sv */
module tect_nbr import tect_pkg::*; (
  input  loc_t                 loc_i,
  input  logic [NUM_DIRS-1:0]  blocked_i,
  input  map_cells_t           map_cells_i,
  input  off_vec_t             offs_i,
  output nbr_t                 nbr_o
);

  logic signed [SUM_W-1:0] sum [NUM_DIRS];
  logic [NUM_DIRS-1:0]     ok;

  always_comb begin
    for (int d = 0; d < NUM_DIRS; d++) begin
      sum[d] = $signed(SUM_W'(loc_i)) + SUM_W'($signed(offs_i[d]));
      ok[d]  = !sum[d][SUM_W-1] && (sum[d][MC_W-1:0] < map_cells_i) && !blocked_i[d];
    end
  end

  // Compact the valid neighbors to the front, keeping direction order.
  always_comb begin
    nbr_o = '0;
    for (int d = 0; d < NUM_DIRS; d++) begin
      if (ok[d]) begin
        nbr_o.list[nbr_o.cnt[NSEL_W-1:0]] = sum[d][LOC_BITS-1:0];
        nbr_o.cnt = nbr_o.cnt + 1'b1;
      end
    end
  end

endmodule

/* rtl/timed_edge_constraint_table.sv */
// A rejected command is answered from the idle state without touching the memories; a vertex
// pop can end early on a mismatch or an empty step, and a query ends early on a hit; the query
// scan reads one stored pair per cycle.
// One command at a time: start is taken when busy is low, which it is in the done_o cycle.
// After reset the depth memory is cleared, one time step per cycle, with busy high.
// done_o is a one-cycle strobe; the receiver cannot stall.
module timed_edge_constraint_table import tect_pkg::*; #(
  parameter int MAX_STEPS      = DEF_MAX_STEPS,
  parameter int PAIRS_PER_STEP = DEF_PAIRS_PER_STEP
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  mode_t                mode_i,
  input  loc_t                 from_loc_i,
  input  loc_t                 to_loc_i,
  input  logic [TIME_W-1:0]    time_step_i,
  input  logic [NUM_DIRS-1:0]  neighbor_blocked_i,
  input  logic                 cfg_we_i,
  input  cfg_idx_t             cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 done_o,
  output logic                 constrained_o,
  output status_t              status_o
);

  localparam int TW  = $clog2(MAX_STEPS);
  localparam int DW  = $clog2(PAIRS_PER_STEP + 1);
  localparam int SW  = DW + 1;
  localparam int PAW = $clog2(MAX_STEPS * PAIRS_PER_STEP);
  localparam int PDW = 2 * LOC_BITS;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DRD0   = 4'd2;
  localparam logic [3:0] S_DRD1   = 4'd3;
  localparam logic [3:0] S_DRD2   = 4'd4;
  localparam logic [3:0] S_EPOP   = 4'd5;
  localparam logic [3:0] S_VPUSH  = 4'd6;
  localparam logic [3:0] S_VPOP0  = 4'd7;
  localparam logic [3:0] S_VPOP0W = 4'd8;
  localparam logic [3:0] S_VPOP1W = 4'd9;
  localparam logic [3:0] S_WD0    = 4'd10;
  localparam logic [3:0] S_WD1    = 4'd11;
  localparam logic [3:0] S_QSCAN  = 4'd12;

  function automatic logic [PAW-1:0] pair_addr(input logic [TW-1:0] ti,
                                               input logic [DW-1:0] k);
    pair_addr = PAW'(ti) * PAW'(PAIRS_PER_STEP) + PAW'(k);
  endfunction

  // Configuration registers.
  map_cells_t map_cells_q;
  off_vec_t   offs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_cells_q <= MAP_CELLS_RST;
      offs_q[0]   <= OFFSET0_RST;
      offs_q[1]   <= OFFSET1_RST;
      offs_q[2]   <= OFFSET2_RST;
      offs_q[3]   <= OFFSET3_RST;
      offs_q[4]   <= OFFSET4_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAP_CELLS: map_cells_q <= cfg_data_i;
        CFG_OFFSET0:   offs_q[0] <= cfg_data_i;
        CFG_OFFSET1:   offs_q[1] <= cfg_data_i;
        CFG_OFFSET2:   offs_q[2] <= cfg_data_i;
        CFG_OFFSET3:   offs_q[3] <= cfg_data_i;
        CFG_OFFSET4:   offs_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  nbr_t nbr_c;

  tect_nbr u_nbr (
    .loc_i       (from_loc_i),
    .blocked_i   (neighbor_blocked_i),
    .map_cells_i (map_cells_q),
    .offs_i      (offs_q),
    .nbr_o       (nbr_c)
  );

  // Memories.
  logic           pair_we;
  logic [PAW-1:0] pair_waddr, pair_raddr;
  logic [PDW-1:0] pair_wdata, pair_rdata;
  logic           depth_we;
  logic [TW-1:0]  depth_waddr, depth_raddr;
  logic [DW-1:0]  depth_wdata, depth_rdata;

  tect_ram #(.DEPTH(MAX_STEPS * PAIRS_PER_STEP), .WIDTH(PDW)) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (pair_we),
    .waddr_i (pair_waddr),
    .wdata_i (pair_wdata),
    .raddr_i (pair_raddr),
    .rdata_o (pair_rdata)
  );

  tect_ram #(.DEPTH(MAX_STEPS), .WIDTH(DW)) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (depth_we),
    .waddr_i (depth_waddr),
    .wdata_i (depth_wdata),
    .raddr_i (depth_raddr),
    .rdata_o (depth_rdata)
  );

  // Sequencer state.
  logic [3:0]        state_q, state_d;
  logic [TW-1:0]     clr_q, clr_d;
  mode_t             mode_q;
  loc_t              a_q, b_q;
  logic [TIME_W-1:0] t_q;
  nbr_t              nbr_q;
  logic [DW-1:0]     d0_q, d0_d, d1_q, d1_d, k_q, k_d;
  cnt_t              vi_q, vi_d;
  logic              ph_q, ph_d, rv_q, rv_d;
  logic              done_q, done_d, hit_q, hit_d;
  status_t           status_q, status_d;

  logic              accept;
  logic              mode_bad, time_bad;
  logic [TW-1:0]     t_idx, t1_idx;
  logic [NSEL_W-1:0] nsel;
  loc_t              nb;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign t_idx  = TW'(t_q);
  assign t1_idx = TW'(7'(t_q) + 7'd1);
  assign nsel   = (state_q == S_VPUSH) ? vi_q[NSEL_W-1:0] : NSEL_W'(vi_q - 1'b1);
  assign nb     = nbr_q.list[nsel];

  always_comb begin
    mode_bad = (mode_i > MODE_QUERY);
    if (mode_i == MODE_PUSH_VTX || mode_i == MODE_POP_VTX) begin
      time_bad = !(32'(time_step_i) + 1 < MAX_STEPS);
    end else begin
      time_bad = !(32'(time_step_i) < MAX_STEPS);
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    d0_d        = d0_q;
    d1_d        = d1_q;
    k_d         = k_q;
    vi_d        = vi_q;
    ph_d        = ph_q;
    rv_d        = rv_q;
    done_d      = 1'b0;
    hit_d       = 1'b0;
    status_d    = status_q;
    pair_we     = 1'b0;
    pair_waddr  = pair_addr(t_idx, d0_q);
    pair_wdata  = {a_q, b_q};
    pair_raddr  = pair_addr(t_idx, k_q);
    depth_we    = 1'b0;
    depth_waddr = t_idx;
    depth_wdata = d0_q;
    depth_raddr = t_idx;

    unique case (state_q)
      S_CLEAR: begin
        depth_we    = 1'b1;
        depth_waddr = clr_q;
        depth_wdata = '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == TW'(MAX_STEPS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (mode_bad) begin
            done_d   = 1'b1;
            status_d = ST_OK;
          end else if (time_bad) begin
            done_d   = 1'b1;
            status_d = ST_TIME;
          end else begin
            state_d = S_DRD0;
          end
        end
      end
      S_DRD0: begin
        state_d = S_DRD1;
      end
      S_DRD1: begin
        d0_d = depth_rdata;
        if (mode_q == MODE_PUSH_VTX || mode_q == MODE_POP_VTX) begin
          depth_raddr = t1_idx;
        end
        state_d = S_DRD2;
      end
      S_DRD2: begin
        d1_d = depth_rdata;
        case (mode_q)
          MODE_PUSH_EDGE: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
            if (d0_q >= DW'(PAIRS_PER_STEP)) begin
              status_d = ST_FULL;
            end else begin
              status_d    = ST_OK;
              pair_we     = 1'b1;
              depth_we    = 1'b1;
              depth_wdata = d0_q + 1'b1;
            end
          end
          MODE_POP_EDGE: begin
            if (d0_q == '0) begin
              done_d   = 1'b1;
              status_d = ST_EMPTY;
              state_d  = S_IDLE;
            end else begin
              pair_raddr = pair_addr(t_idx, d0_q - 1'b1);
              state_d    = S_EPOP;
            end
          end
          MODE_PUSH_VTX: begin
            if ((SW'(d0_q) + SW'(nbr_q.cnt) > SW'(PAIRS_PER_STEP)) ||
                (SW'(depth_rdata) + SW'(nbr_q.cnt) > SW'(PAIRS_PER_STEP))) begin
              done_d   = 1'b1;
              status_d = ST_FULL;
              state_d  = S_IDLE;
            end else begin
              vi_d    = '0;
              ph_d    = 1'b0;
              state_d = S_VPUSH;
            end
          end
          MODE_POP_VTX: begin
            vi_d    = nbr_q.cnt;
            state_d = S_VPOP0;
          end
          MODE_QUERY: begin
            if (t_q == '0) begin
              done_d   = 1'b1;
              status_d = ST_OK;
              state_d  = S_IDLE;
            end else begin
              k_d     = '0;
              rv_d    = 1'b0;
              state_d = S_QSCAN;
            end
          end
          default: begin
            done_d   = 1'b1;
            status_d = ST_OK;
            state_d  = S_IDLE;
          end
        endcase
      end
      S_EPOP: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (pair_rdata == {a_q, b_q}) begin
          status_d    = ST_OK;
          depth_we    = 1'b1;
          depth_wdata = d0_q - 1'b1;
        end else begin
          status_d = ST_MISMATCH;
        end
      end
      S_VPUSH: begin
        // Each neighbor adds (loc, n) at t+1, then (n, loc) at t.
        if (vi_q == nbr_q.cnt) begin
          state_d = S_WD0;
        end else if (!ph_q) begin
          pair_we    = 1'b1;
          pair_waddr = pair_addr(t1_idx, d1_q);
          pair_wdata = {a_q, nb};
          d1_d       = d1_q + 1'b1;
          ph_d       = 1'b1;
        end else begin
          pair_we    = 1'b1;
          pair_waddr = pair_addr(t_idx, d0_q);
          pair_wdata = {nb, a_q};
          d0_d       = d0_q + 1'b1;
          ph_d       = 1'b0;
          vi_d       = vi_q + 1'b1;
        end
      end
      S_VPOP0: begin
        if (vi_q == '0) begin
          state_d = S_WD0;
        end else if (d0_q == '0) begin
          done_d   = 1'b1;
          status_d = ST_EMPTY;
          state_d  = S_IDLE;
        end else begin
          pair_raddr = pair_addr(t_idx, d0_q - 1'b1);
          state_d    = S_VPOP0W;
        end
      end
      S_VPOP0W: begin
        if (pair_rdata != {nb, a_q}) begin
          done_d   = 1'b1;
          status_d = ST_MISMATCH;
          state_d  = S_IDLE;
        end else if (d1_q == '0) begin
          done_d   = 1'b1;
          status_d = ST_EMPTY;
          state_d  = S_IDLE;
        end else begin
          d0_d       = d0_q - 1'b1;
          pair_raddr = pair_addr(t1_idx, d1_q - 1'b1);
          state_d    = S_VPOP1W;
        end
      end
      S_VPOP1W: begin
        if (pair_rdata != {a_q, nb}) begin
          done_d   = 1'b1;
          status_d = ST_MISMATCH;
          state_d  = S_IDLE;
        end else begin
          d1_d    = d1_q - 1'b1;
          vi_d    = vi_q - 1'b1;
          state_d = S_VPOP0;
        end
      end
      S_WD0: begin
        depth_we = 1'b1;
        state_d  = S_WD1;
      end
      S_WD1: begin
        depth_we    = 1'b1;
        depth_waddr = t1_idx;
        depth_wdata = d1_q;
        done_d      = 1'b1;
        status_d    = ST_OK;
        state_d     = S_IDLE;
      end
      S_QSCAN: begin
        // One read issued per cycle; the compare takes the data of each read in the cycle after it.
        if (rv_q && pair_rdata == {a_q, b_q}) begin
          done_d   = 1'b1;
          hit_d    = 1'b1;
          status_d = ST_OK;
          state_d  = S_IDLE;
        end else if (k_q < d0_q) begin
          pair_raddr = pair_addr(t_idx, k_q);
          k_d        = k_q + 1'b1;
          rv_d       = 1'b1;
        end else begin
          done_d   = 1'b1;
          status_d = ST_OK;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
      status_q <= ST_OK;
      ph_q     <= 1'b0;
      rv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      done_q   <= done_d;
      hit_q    <= hit_d;
      status_q <= status_d;
      ph_q     <= ph_d;
      rv_q     <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      a_q    <= from_loc_i;
      b_q    <= to_loc_i;
      t_q    <= time_step_i;
      nbr_q  <= nbr_c;
    end
    d0_q <= d0_d;
    d1_q <= d1_d;
    k_q  <= k_d;
    vi_q <= vi_d;
  end

  assign done_o        = done_q;
  assign constrained_o = hit_q;
  assign status_o      = status_q;

endmodule
